### rtl/assert_macros.svh
// Assertion macros shared by the speed loop RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSTL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSTL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pstl_pkg.sv
// Shared types and constants of the speed throttle loop.
`timescale 1ns / 1ps
package pstl_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int GAIN_W     = 24;
    localparam int SUM_W      = 32;
    localparam int THR_W      = 10;
    localparam int TGT_W      = 16;
    localparam int DB_W       = 15;
    localparam int LIM_W      = 15;

    localparam logic [THR_W-1:0] THROTTLE_MAX = 10'd1000;

    localparam logic signed [TGT_W-1:0] RST_TARGET   = 16'sd0;
    localparam logic [DB_W-1:0]         RST_DEADBAND = 15'd50;
    localparam logic [GAIN_W-1:0]       RST_KP       = 24'd13107;
    localparam logic [GAIN_W-1:0]       RST_KI       = 24'd46;
    localparam logic [GAIN_W-1:0]       RST_KD       = 24'd0;
    localparam logic [LIM_W-1:0]        RST_LAUNCH   = 15'd100;
    localparam logic [THR_W-1:0]        RST_MIN_THR  = 10'd150;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET   = 3'd0,
        REG_DEADBAND = 3'd1,
        REG_KP       = 3'd2,
        REG_KI       = 3'd3,
        REG_KD       = 3'd4,
        REG_LAUNCH   = 3'd5,
        REG_MIN_THR  = 3'd6
    } pstl_reg_t;

    typedef struct packed {
        logic signed [TGT_W-1:0] setpoint;
        logic [DB_W-1:0]         error_deadband;
        logic [GAIN_W-1:0]       proportional_gain;
        logic [GAIN_W-1:0]       integral_gain;
        logic [GAIN_W-1:0]       derivative_gain;
        logic [LIM_W-1:0]        launch_speed_limit;
        logic [THR_W-1:0]        min_launch_throttle;
    } pstl_cfg_t;

endpackage

### rtl/pid_speed_throttle_loop_unit.sv
// Top level of the speed PID loop with error deadband and launch minimum.
`timescale 1ns / 1ps
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  sample   | sample_valid / sample_ready | measured_speed
//  result   | result_valid / result_ready | throttle, launch_boost
//  config   | cfg_we (no wait)            | cfg_index, cfg_data
//
//  One sample beat per cycle is taken while sample_ready is high; its result passes
//  through the error/integral register, the product register and the result
//  register before it is offered as a result beat.
//  A sample inside the deadband produces no result beat and leaves the loop state alone.
//  The integral and last error update at the sample beat itself, so back-to-back
//  samples chain through the state.
//  A stalled result holds the result register; stages behind it keep filling
//  until each is occupied, then sample_ready drops.
//  Reset clears the valid flags, the integral and the last error at once.
//
module pid_speed_throttle_loop_unit
    import pstl_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16,
    parameter int SPEED_WIDTH    = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SPEED_WIDTH-1:0] measured_speed,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [THR_W-1:0]              throttle,
    output logic                          launch_boost
);

    localparam int EW = ((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W) + 1;
    localparam int PW = EW + GAIN_W + 1;
    localparam int IW = SUM_W + GAIN_W + 1;
    localparam int DW = EW + GAIN_W + 2;

    pstl_cfg_t               cfg;

    // front stage outputs
    logic                    s1_valid;
    logic                    s1_adv;
    logic signed [EW-1:0]    s1_err;
    logic signed [SUM_W-1:0] s1_sum;
    logic signed [EW:0]      s1_diff;
    logic                    s1_launch;

    // product stage outputs
    logic                    s2_valid;
    logic                    s2_adv;
    logic signed [PW-1:0]    s2_p;
    logic signed [IW-1:0]    s2_i;
    logic signed [DW-1:0]    s2_d;
    logic                    s2_launch;

    pstl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // error, deadband test and the loop state (integral, last error)
    pstl_err_stage #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_err (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .measured_speed (measured_speed),
        .adv            (s1_adv),
        .s1_valid       (s1_valid),
        .s1_err         (s1_err),
        .s1_sum         (s1_sum),
        .s1_diff        (s1_diff),
        .s1_launch      (s1_launch)
    );

    // Kp*e, Ki*sum and Kd*(e - last e) in parallel
    pstl_mul_stage #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s1_valid  (s1_valid),
        .s1_adv    (s1_adv),
        .s1_err    (s1_err),
        .s1_sum    (s1_sum),
        .s1_diff   (s1_diff),
        .s1_launch (s1_launch),
        .adv       (s2_adv),
        .s2_valid  (s2_valid),
        .s2_p      (s2_p),
        .s2_i      (s2_i),
        .s2_d      (s2_d),
        .s2_launch (s2_launch)
    );

    // add, drop the fraction, clamp to full scale, apply launch minimum
    pstl_out_stage #(
        .SPEED_WIDTH    (SPEED_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .s2_valid     (s2_valid),
        .s2_adv       (s2_adv),
        .s2_p         (s2_p),
        .s2_i         (s2_i),
        .s2_d         (s2_d),
        .s2_launch    (s2_launch),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .throttle     (throttle),
        .launch_boost (launch_boost)
    );

endmodule

### rtl/pstl_cfg_regs.sv
// Configuration register file of the speed throttle loop.
`timescale 1ns / 1ps
module pstl_cfg_regs
    import pstl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output pstl_cfg_t             cfg
);

    pstl_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint            <= RST_TARGET;
            cfg_reg.error_deadband      <= RST_DEADBAND;
            cfg_reg.proportional_gain   <= RST_KP;
            cfg_reg.integral_gain       <= RST_KI;
            cfg_reg.derivative_gain     <= RST_KD;
            cfg_reg.launch_speed_limit  <= RST_LAUNCH;
            cfg_reg.min_launch_throttle <= RST_MIN_THR;
        end
        else if (cfg_we)
        begin
            unique case (pstl_reg_t'(cfg_index))
                REG_TARGET:   cfg_reg.setpoint            <= $signed(cfg_data[TGT_W-1:0]);
                REG_DEADBAND: cfg_reg.error_deadband      <= cfg_data[DB_W-1:0];
                REG_KP:       cfg_reg.proportional_gain   <= cfg_data[GAIN_W-1:0];
                REG_KI:       cfg_reg.integral_gain       <= cfg_data[GAIN_W-1:0];
                REG_KD:       cfg_reg.derivative_gain     <= cfg_data[GAIN_W-1:0];
                REG_LAUNCH:   cfg_reg.launch_speed_limit  <= cfg_data[LIM_W-1:0];
                REG_MIN_THR:  cfg_reg.min_launch_throttle <= cfg_data[THR_W-1:0];
                default:      ;  // unmapped index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pstl_err_stage.sv
// Front stage: error, deadband, saturating integral and loop state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pstl_err_stage
    import pstl_pkg::*;
#(
    parameter int SPEED_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pstl_cfg_t                     cfg,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SPEED_WIDTH-1:0] measured_speed,
    input  logic                          adv,
    output logic                          s1_valid,
    output logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W):0] s1_err,
    output logic signed [SUM_W-1:0]       s1_sum,
    output logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W)+1:0] s1_diff,
    output logic                          s1_launch
);

    localparam int EW = ((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W) + 1;

    logic signed [EW-1:0]    err;
    logic [EW-1:0]           mag;
    logic                    in_db;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [EW:0]      diff;
    logic signed [EW-1:0]    speed_ext;
    logic                    launch;
    logic                    fire;
    logic                    en;

    logic                    s1_valid_reg;
    logic signed [EW-1:0]    s1_err_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic signed [EW:0]      s1_diff_reg;
    logic                    s1_launch_reg;
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [EW-1:0]    last_error_reg;

    assign en           = !s1_valid_reg || adv;
    assign sample_ready = en;
    assign fire         = sample_valid && en;

    always_comb
    begin
        speed_ext = {{(EW-SPEED_WIDTH){measured_speed[SPEED_WIDTH-1]}}, measured_speed};
        err       = {{(EW-TGT_W){cfg.setpoint[TGT_W-1]}}, cfg.setpoint} - speed_ext;
        mag       = err[EW-1] ? -err : err;
        in_db     = mag < {{(EW-DB_W){1'b0}}, cfg.error_deadband};
        launch    = speed_ext < $signed({{(EW-LIM_W){1'b0}}, cfg.launch_speed_limit});
        diff      = {err[EW-1], err} - {last_error_reg[EW-1], last_error_reg};
        sum_wide  = {error_sum_reg[SUM_W-1], error_sum_reg}
                  + {{(SUM_W+1-EW){err[EW-1]}}, err};
        // clamp at the signed 32-bit limits when the carry disagrees with the sign
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            if (en)
                s1_valid_reg <= fire && !in_db;
            if (fire && !in_db)
            begin
                error_sum_reg  <= sum_sat;
                last_error_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_err_reg    <= err;
            s1_sum_reg    <= sum_sat;
            s1_diff_reg   <= diff;
            s1_launch_reg <= launch;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_err    = s1_err_reg;
    assign s1_sum    = s1_sum_reg;
    assign s1_diff   = s1_diff_reg;
    assign s1_launch = s1_launch_reg;

    `PSTL_ASSERT_NXT(a_db_holds_sum, fire && in_db, $stable(error_sum_reg), "deadband beat moved the integral")
    `PSTL_ASSERT_IMP(a_s1_from_beat, $rose(s1_valid_reg), $past(fire), "stage 1 filled without a beat")

endmodule

### rtl/pstl_mul_stage.sv
// Product stage: the three gain multiplies, each registered.
`timescale 1ns / 1ps
module pstl_mul_stage
    import pstl_pkg::*;
#(
    parameter int SPEED_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pstl_cfg_t               cfg,
    input  logic                    s1_valid,
    output logic                    s1_adv,
    input  logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W):0] s1_err,
    input  logic signed [SUM_W-1:0] s1_sum,
    input  logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W)+1:0] s1_diff,
    input  logic                    s1_launch,
    input  logic                    adv,
    output logic                    s2_valid,
    output logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W)+GAIN_W+1:0] s2_p,
    output logic signed [SUM_W+GAIN_W:0] s2_i,
    output logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W)+GAIN_W+2:0] s2_d,
    output logic                    s2_launch
);

    localparam int EW = ((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W) + 1;
    localparam int PW = EW + GAIN_W + 1;
    localparam int IW = SUM_W + GAIN_W + 1;
    localparam int DW = EW + GAIN_W + 2;

    logic                 en;
    logic signed [PW-1:0] p_next;
    logic signed [IW-1:0] i_next;
    logic signed [DW-1:0] d_next;

    logic                 s2_valid_reg;
    logic signed [PW-1:0] s2_p_reg;
    logic signed [IW-1:0] s2_i_reg;
    logic signed [DW-1:0] s2_d_reg;
    logic                 s2_launch_reg;

    assign en     = !s2_valid_reg || adv;
    assign s1_adv = en;

    assign p_next = $signed({1'b0, cfg.proportional_gain}) * s1_err;
    assign i_next = $signed({1'b0, cfg.integral_gain}) * s1_sum;
    assign d_next = $signed({1'b0, cfg.derivative_gain}) * s1_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_valid)
        begin
            s2_p_reg      <= p_next;
            s2_i_reg      <= i_next;
            s2_d_reg      <= d_next;
            s2_launch_reg <= s1_launch;
        end
    end

    assign s2_valid  = s2_valid_reg;
    assign s2_p      = s2_p_reg;
    assign s2_i      = s2_i_reg;
    assign s2_d      = s2_d_reg;
    assign s2_launch = s2_launch_reg;

endmodule

### rtl/pstl_out_stage.sv
// Result stage: sum of products, scaling, clamp and launch minimum.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pstl_out_stage
    import pstl_pkg::*;
#(
    parameter int SPEED_WIDTH    = 16,
    parameter int GAIN_FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pstl_cfg_t               cfg,
    input  logic                    s2_valid,
    output logic                    s2_adv,
    input  logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W)+GAIN_W+1:0] s2_p,
    input  logic signed [SUM_W+GAIN_W:0] s2_i,
    input  logic signed [((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W)+GAIN_W+2:0] s2_d,
    input  logic                    s2_launch,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [THR_W-1:0]        throttle,
    output logic                    launch_boost
);

    localparam int EW = ((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W) + 1;
    localparam int PW = EW + GAIN_W + 1;
    localparam int IW = SUM_W + GAIN_W + 1;
    localparam int DW = EW + GAIN_W + 2;
    localparam int AW = ((IW > DW) ? IW : DW) + 2;

    logic                 en;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] scaled;
    logic [AW-1:0]        min_lim;
    logic                 pos;
    logic                 boost;
    logic [THR_W-1:0]     forced;
    logic [THR_W-1:0]     thr_next;

    logic                 result_valid_reg;
    logic [THR_W-1:0]     throttle_reg;
    logic                 launch_boost_reg;

    assign en     = !result_valid_reg || result_ready;
    assign s2_adv = en;

    always_comb
    begin
        acc     = {{(AW-PW){s2_p[PW-1]}}, s2_p}
                + {{(AW-IW){s2_i[IW-1]}}, s2_i}
                + {{(AW-DW){s2_d[DW-1]}}, s2_d};
        pos     = !acc[AW-1] && (acc != '0);
        scaled  = acc >>> GAIN_FRAC_BITS;
        min_lim = {{(AW-THR_W){1'b0}}, cfg.min_launch_throttle} << GAIN_FRAC_BITS;
        boost   = pos && s2_launch && ($unsigned(acc) < min_lim);
        forced  = (cfg.min_launch_throttle > THROTTLE_MAX) ? THROTTLE_MAX
                                                           : cfg.min_launch_throttle;
        priority if (boost)
            thr_next = forced;
        else if (!pos)
            thr_next = '0;
        else if ($unsigned(scaled) > {{(AW-THR_W){1'b0}}, THROTTLE_MAX})
            thr_next = THROTTLE_MAX;
        else
            thr_next = scaled[THR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid)
        begin
            throttle_reg     <= thr_next;
            launch_boost_reg <= boost;
        end
    end

    assign result_valid = result_valid_reg;
    assign throttle     = throttle_reg;
    assign launch_boost = launch_boost_reg;

    `PSTL_ASSERT_IMP(a_thr_range, result_valid_reg, throttle_reg <= THROTTLE_MAX, "throttle above full scale")
    `PSTL_ASSERT_IMP(a_boost_nonzero, result_valid_reg && launch_boost_reg, throttle_reg != '0, "launch boost with zero throttle")

endmodule
